/* rtl/sfk_pkg.sv */
`default_nettype none
package sfk_pkg;

  localparam int MAX_JOINTS_DEF = 64;

  localparam int IN_TDATA_W  = 264;
  localparam int OUT_TDATA_W = 168;
  localparam int QW          = 16;
  localparam int PW          = 32;
  localparam int PARENT_W    = 7;
  localparam int JIDX_W      = 6;

  // operand and accumulator widths of the shared multiply-add unit
  localparam int AW_OP   = 17;
  localparam int BW_OP   = 37;
  localparam int PROD_W  = 54;
  localparam int SUM_W   = 56;
  localparam int ROT_W   = 42;
  localparam int POSS_W  = 44;
  localparam int STORE_W = 4 * QW + 3 * PW;

  localparam logic signed [PARENT_W-1:0] ROOT_PARENT = -7'sd1;
  localparam logic signed [QW-1:0]       Q_ONE       = 16'sd16384;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_QW = 4'd0;
  localparam logic [STEP_W-1:0] STEP_QX = 4'd1;
  localparam logic [STEP_W-1:0] STEP_QY = 4'd2;
  localparam logic [STEP_W-1:0] STEP_QZ = 4'd3;
  localparam logic [STEP_W-1:0] STEP_TX = 4'd4;
  localparam logic [STEP_W-1:0] STEP_TY = 4'd5;
  localparam logic [STEP_W-1:0] STEP_TZ = 4'd6;
  localparam logic [STEP_W-1:0] STEP_RX = 4'd7;
  localparam logic [STEP_W-1:0] STEP_RY = 4'd8;
  localparam logic [STEP_W-1:0] STEP_RZ = 4'd9;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_RZ;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_CALC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              cap;
    logic              load;
    logic              calc;
    logic [STEP_W-1:0] step;
    logic              fin;
  } cmd_t;

endpackage
`default_nettype wire

/* rtl/sfk_ram.sv */
`default_nettype none
module sfk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* rtl/sfk_ctrl.sv */
`default_nettype none
module sfk_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output sfk_pkg::cmd_t      cmd
);

  sfk_pkg::state_t                state_r, state_nxt;
  logic [sfk_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      sfk_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = sfk_pkg::ST_READ;
      end
      sfk_pkg::ST_READ: state_nxt = sfk_pkg::ST_LOAD;
      sfk_pkg::ST_LOAD: begin
        state_nxt = sfk_pkg::ST_CALC;
        step_nxt  = sfk_pkg::STEP_QW;
      end
      sfk_pkg::ST_CALC: begin
        if (step_r == sfk_pkg::STEP_LAST) state_nxt = sfk_pkg::ST_DONE;
        else step_nxt = step_r + 1'b1;
      end
      sfk_pkg::ST_DONE: begin
        if (out_free) state_nxt = sfk_pkg::ST_IDLE;
      end
      default: state_nxt = sfk_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == sfk_pkg::ST_IDLE);
    cmd.cap   = in_tready && in_tvalid;
    cmd.load  = (state_r == sfk_pkg::ST_LOAD);
    cmd.calc  = (state_r == sfk_pkg::ST_CALC);
    cmd.step  = step_r;
    cmd.fin   = (state_r == sfk_pkg::ST_DONE) && out_free;
    if (cmd.fin) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sfk_pkg::ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

/* rtl/sfk_dp.sv */
`default_nettype none
module sfk_dp #(
  parameter int MAX_JOINTS = sfk_pkg::MAX_JOINTS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire sfk_pkg::cmd_t                    cmd,
  input  wire logic [sfk_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic                             in_tlast,
  output logic      [sfk_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                                  out_tuser
);

  localparam int IW   = $clog2(MAX_JOINTS);
  localparam int CMPW = ((IW > sfk_pkg::JIDX_W) ? IW : sfk_pkg::JIDX_W) + 1;
  localparam int QW   = sfk_pkg::QW;
  localparam int PW   = sfk_pkg::PW;
  localparam int AOW  = sfk_pkg::AW_OP;
  localparam int BOW  = sfk_pkg::BW_OP;
  localparam int SW   = sfk_pkg::SUM_W;

  // captured input word
  logic signed [sfk_pkg::PARENT_W-1:0] parent_r;
  logic signed [QW-1:0]  loc_r  [4];
  logic signed [PW-1:0]  off_r  [3];
  logic signed [PW-1:0]  root_r [3];
  logic                  last_r;
  logic [IW-1:0]         cnt_r;

  // parent state and per-step results
  logic signed [QW-1:0]  pq_r [4];
  logic signed [PW-1:0]  pp_r [3];
  logic signed [QW-1:0]  gq_r [4];
  logic signed [BOW-1:0] t_r  [3];
  logic signed [sfk_pkg::ROT_W-1:0] rot_r [3];

  logic [sfk_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic                            out_tuser_r;

  logic is_neg1, bad, is_root;
  logic [IW-1:0] raddr;
  logic [sfk_pkg::STORE_W-1:0] rdata, wdata;

  logic signed [AOW-1:0] a_op [4];
  logic signed [BOW-1:0] b_op [4];
  logic signed [sfk_pkg::PROD_W-1:0] prod [4];
  logic signed [SW-1:0] sum, sum2, rnd, rnd2;
  logic signed [QW-1:0] sat_q;
  logic signed [PW-1:0] pos [3];
  logic signed [sfk_pkg::POSS_W-1:0] psum [3];

  function automatic logic signed [AOW-1:0] pa(input logic signed [QW-1:0] v);
    return AOW'(v);
  endfunction

  function automatic logic signed [AOW-1:0] na(input logic signed [QW-1:0] v);
    return -AOW'(v);
  endfunction

  assign is_neg1 = (parent_r == sfk_pkg::ROOT_PARENT);
  assign bad     = !is_neg1 &&
                   (parent_r[sfk_pkg::PARENT_W-1] ||
                    (CMPW'(parent_r[sfk_pkg::JIDX_W-1:0]) >= CMPW'(cnt_r)));
  assign is_root = is_neg1 || bad;
  assign raddr   = is_root ? '0 : IW'(parent_r[sfk_pkg::JIDX_W-1:0]);

  // operand select for the shared four-product multiply-add
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      a_op[i] = '0;
      b_op[i] = '0;
    end
    unique case (cmd.step)
      sfk_pkg::STEP_QW: begin
        a_op[0] = pa(pq_r[0]); b_op[0] = BOW'(loc_r[0]);
        a_op[1] = na(pq_r[1]); b_op[1] = BOW'(loc_r[1]);
        a_op[2] = na(pq_r[2]); b_op[2] = BOW'(loc_r[2]);
        a_op[3] = na(pq_r[3]); b_op[3] = BOW'(loc_r[3]);
      end
      sfk_pkg::STEP_QX: begin
        a_op[0] = pa(pq_r[0]); b_op[0] = BOW'(loc_r[1]);
        a_op[1] = pa(pq_r[1]); b_op[1] = BOW'(loc_r[0]);
        a_op[2] = pa(pq_r[2]); b_op[2] = BOW'(loc_r[3]);
        a_op[3] = na(pq_r[3]); b_op[3] = BOW'(loc_r[2]);
      end
      sfk_pkg::STEP_QY: begin
        a_op[0] = pa(pq_r[0]); b_op[0] = BOW'(loc_r[2]);
        a_op[1] = na(pq_r[1]); b_op[1] = BOW'(loc_r[3]);
        a_op[2] = pa(pq_r[2]); b_op[2] = BOW'(loc_r[0]);
        a_op[3] = pa(pq_r[3]); b_op[3] = BOW'(loc_r[1]);
      end
      sfk_pkg::STEP_QZ: begin
        a_op[0] = pa(pq_r[0]); b_op[0] = BOW'(loc_r[3]);
        a_op[1] = pa(pq_r[1]); b_op[1] = BOW'(loc_r[2]);
        a_op[2] = na(pq_r[2]); b_op[2] = BOW'(loc_r[1]);
        a_op[3] = pa(pq_r[3]); b_op[3] = BOW'(loc_r[0]);
      end
      sfk_pkg::STEP_TX: begin
        a_op[0] = pa(pq_r[2]); b_op[0] = BOW'(off_r[2]);
        a_op[1] = na(pq_r[3]); b_op[1] = BOW'(off_r[1]);
      end
      sfk_pkg::STEP_TY: begin
        a_op[0] = pa(pq_r[3]); b_op[0] = BOW'(off_r[0]);
        a_op[1] = na(pq_r[1]); b_op[1] = BOW'(off_r[2]);
      end
      sfk_pkg::STEP_TZ: begin
        a_op[0] = pa(pq_r[1]); b_op[0] = BOW'(off_r[1]);
        a_op[1] = na(pq_r[2]); b_op[1] = BOW'(off_r[0]);
      end
      sfk_pkg::STEP_RX: begin
        a_op[0] = pa(pq_r[0]); b_op[0] = t_r[0];
        a_op[1] = pa(pq_r[2]); b_op[1] = t_r[2];
        a_op[2] = na(pq_r[3]); b_op[2] = t_r[1];
      end
      sfk_pkg::STEP_RY: begin
        a_op[0] = pa(pq_r[0]); b_op[0] = t_r[1];
        a_op[1] = pa(pq_r[3]); b_op[1] = t_r[0];
        a_op[2] = na(pq_r[1]); b_op[2] = t_r[2];
      end
      sfk_pkg::STEP_RZ: begin
        a_op[0] = pa(pq_r[0]); b_op[0] = t_r[2];
        a_op[1] = pa(pq_r[1]); b_op[1] = t_r[1];
        a_op[2] = na(pq_r[2]); b_op[2] = t_r[0];
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 4; i++) prod[i] = a_op[i] * b_op[i];
    sum  = SW'(prod[0]) + SW'(prod[1]) + SW'(prod[2]) + SW'(prod[3]);
    sum2 = sum <<< 1;
    rnd  = (sum + SW'(8192)) >>> 14;
    rnd2 = (sum2 + SW'(8192)) >>> 14;
    if (rnd > SW'(32767)) sat_q = 16'sh7FFF;
    else if (rnd < -SW'(32768)) sat_q = -16'sh8000;
    else sat_q = QW'(rnd);
  end

  // parent position + offset + rotated offset, clamped to 32 bits; root position for roots
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      psum[i] = sfk_pkg::POSS_W'(pp_r[i]) + sfk_pkg::POSS_W'(off_r[i]) +
                sfk_pkg::POSS_W'(rot_r[i]);
      if (is_root) pos[i] = root_r[i];
      else if (psum[i] > sfk_pkg::POSS_W'(32'sh7FFFFFFF)) pos[i] = 32'sh7FFFFFFF;
      else if (psum[i] < -sfk_pkg::POSS_W'(64'sh80000000)) pos[i] = -32'sh80000000;
      else pos[i] = PW'(psum[i]);
    end
  end

  assign wdata = {gq_r[0], gq_r[1], gq_r[2], gq_r[3], pos[0], pos[1], pos[2]};

  sfk_ram #(
    .WIDTH (sfk_pkg::STORE_W),
    .DEPTH (MAX_JOINTS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.fin),
    .waddr (cnt_r),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      parent_r <= in_tdata[6:0];
      for (int i = 0; i < 4; i++) loc_r[i] <= in_tdata[7 + 16*i +: 16];
      for (int i = 0; i < 3; i++) begin
        off_r[i]  <= in_tdata[71 + 32*i +: 32];
        root_r[i] <= in_tdata[167 + 32*i +: 32];
      end
      last_r <= in_tlast;
    end
    if (cmd.load) begin
      if (is_root && cnt_r == '0) begin
        pq_r[0] <= sfk_pkg::Q_ONE;
        pq_r[1] <= '0;
        pq_r[2] <= '0;
        pq_r[3] <= '0;
      end else begin
        for (int i = 0; i < 4; i++) pq_r[i] <= rdata[160 - 16*(i+1) +: 16];
      end
      for (int i = 0; i < 3; i++) pp_r[i] <= rdata[96 - 32*(i+1) +: 32];
    end
    if (cmd.calc) begin
      priority if (cmd.step <= sfk_pkg::STEP_QZ) begin
        gq_r[cmd.step[1:0]] <= sat_q;
      end else if (cmd.step <= sfk_pkg::STEP_TZ) begin
        t_r[2'(cmd.step - sfk_pkg::STEP_TX)] <= BOW'(rnd2);
      end else begin
        rot_r[2'(cmd.step - sfk_pkg::STEP_RX)] <= sfk_pkg::ROT_W'(rnd);
      end
    end
    if (cmd.fin) begin
      out_tdata_r <= {2'b00, pos[2], pos[1], pos[0],
                      gq_r[3], gq_r[2], gq_r[1], gq_r[0],
                      sfk_pkg::JIDX_W'(cnt_r)};
      out_tuser_r <= bad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.fin) begin
      if (last_r || cnt_r == IW'(MAX_JOINTS - 1)) cnt_r <= '0;
      else cnt_r <= cnt_r + 1'b1;
    end
  end

  assign out_tdata = out_tdata_r;
  assign out_tuser = out_tuser_r;

endmodule
`default_nettype wire

/* rtl/skeleton_forward_kinematics.sv */
`default_nettype none
// Skeletal forward kinematics, one joint per word. Send the joints of a pose in index
// order with tlast on the final joint; the joint counter restarts after it and wraps
// after MAX_JOINTS-1. Each result word carries the joint index, the global orientation
// (parent orientation times local rotation, Q2.14, rounded and saturated) and the
// global position (parent position plus the offset rotated by the parent orientation,
// Q16.16, saturated); root joints take the root position. out_tuser flags a parent
// index that is negative (other than -1) or not below the joint index, and such a joint
// is handled as a root. From acceptance a joint passes through an accept, a registered
// read of the joint store, a load, ten steps of a shared four-product multiply-add unit
// (four quaternion components, three cross-product terms, three rotation terms) and a
// write-back that waits for a free output register. The next word is accepted once the
// write-back is done, while the previous result may still wait in the output register.
module skeleton_forward_kinematics #(
  parameter int MAX_JOINTS = sfk_pkg::MAX_JOINTS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // parent_index[6:0], local_rot_w/x/y/z[70:7], offset_x/y/z[166:71],
  // root_pos_x/y/z[262:167], zero pad [263]
  input  wire logic [sfk_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic                             in_tlast,   // last_joint
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // joint_index[5:0], global_rot_w/x/y/z[69:6], global_pos_x/y/z[165:70],
  // zero pad [167:166]
  output logic      [sfk_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                                  out_tuser   // bad_parent
);

  sfk_pkg::cmd_t cmd;

  sfk_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  sfk_dp #(
    .MAX_JOINTS (MAX_JOINTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // write back only into a free output register
  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> (!out_tvalid || out_tready))
    else $error("result loaded over a pending word");

  // a loaded result shows up as valid
  a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> out_tvalid)
    else $error("result lost after write-back");

  // hold off new words while a joint is in flight
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second word accepted during a joint");

endmodule
`default_nettype wire

/* tb/skeleton_forward_kinematics_test.sv */
`default_nettype none
module skeleton_forward_kinematics_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NJ = sfk_pkg::MAX_JOINTS_DEF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic signed [sfk_pkg::PARENT_W-1:0] parent;
    logic signed [sfk_pkg::QW-1:0] qw, qx, qy, qz;
    logic signed [sfk_pkg::PW-1:0] ox, oy, oz;
    logic signed [sfk_pkg::PW-1:0] rx, ry, rz;
    logic last;
  } joint_word_t;

  typedef struct packed {
    logic [sfk_pkg::JIDX_W-1:0] idx;
    logic signed [sfk_pkg::QW-1:0] qw, qx, qy, qz;
    logic signed [sfk_pkg::PW-1:0] px, py, pz;
    logic bad;
  } pose_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [sfk_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [sfk_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;

  always #5 clk = ~clk;

  skeleton_forward_kinematics uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // predictor state: joint counter and per-joint global pose
  int unsigned fk_count;
  logic signed [sfk_pkg::QW-1:0] fk_rot[NJ][4];
  logic signed [sfk_pkg::PW-1:0] fk_pos[NJ][3];

  joint_word_t joint_queue[$];
  pose_word_t pose_queue[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;
  bit quiet = 1'b0;   // no idling on either side while set

  function automatic void queue_joint(joint_word_t j);
    joint_queue.insert(joint_queue.size(), j);
  endfunction

  function automatic longint rnd14(longint x);
    return (x + 8192) >>> 14;
  endfunction

  function automatic longint clip(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  // compute the global pose of one joint and update the joint store
  function automatic pose_word_t solve_joint(joint_word_t j);
    pose_word_t r;
    longint p[4], l[4], v[3], s[4], t[3], u[3];
    longint pp[3];
    bit root;
    int c;
    c = fk_count;
    r.bad = 1'b0;
    root = 1'b1;
    if (j.parent != sfk_pkg::ROOT_PARENT) begin
      if (j.parent < 0 || int'(j.parent) >= c) r.bad = 1'b1;
      else root = 1'b0;
    end
    if (root && c == 0) begin
      p[0] = sfk_pkg::Q_ONE; p[1] = 0; p[2] = 0; p[3] = 0;
    end else begin
      for (int i = 0; i < 4; i++) p[i] = fk_rot[root ? 0 : int'(j.parent)][i];
    end
    for (int i = 0; i < 3; i++) pp[i] = root ? 0 : fk_pos[int'(j.parent)][i];
    l[0] = j.qw; l[1] = j.qx; l[2] = j.qy; l[3] = j.qz;
    v[0] = j.ox; v[1] = j.oy; v[2] = j.oz;
    s[0] = p[0]*l[0] - p[1]*l[1] - p[2]*l[2] - p[3]*l[3];
    s[1] = p[0]*l[1] + p[1]*l[0] + p[2]*l[3] - p[3]*l[2];
    s[2] = p[0]*l[2] - p[1]*l[3] + p[2]*l[0] + p[3]*l[1];
    s[3] = p[0]*l[3] + p[1]*l[2] - p[2]*l[1] + p[3]*l[0];
    for (int i = 0; i < 4; i++) s[i] = clip(rnd14(s[i]), -32768, 32767);
    t[0] = rnd14(2 * (p[2]*v[2] - p[3]*v[1]));
    t[1] = rnd14(2 * (p[3]*v[0] - p[1]*v[2]));
    t[2] = rnd14(2 * (p[1]*v[1] - p[2]*v[0]));
    u[0] = rnd14(p[0]*t[0] + p[2]*t[2] - p[3]*t[1]);
    u[1] = rnd14(p[0]*t[1] + p[3]*t[0] - p[1]*t[2]);
    u[2] = rnd14(p[0]*t[2] + p[1]*t[1] - p[2]*t[0]);
    r.idx = c[sfk_pkg::JIDX_W-1:0];
    r.qw = sfk_pkg::QW'(s[0]); r.qx = sfk_pkg::QW'(s[1]);
    r.qy = sfk_pkg::QW'(s[2]); r.qz = sfk_pkg::QW'(s[3]);
    if (root) begin
      r.px = j.rx; r.py = j.ry; r.pz = j.rz;
    end else begin
      r.px = sfk_pkg::PW'(clip(pp[0] + v[0] + u[0], -64'sd2147483648, 64'sd2147483647));
      r.py = sfk_pkg::PW'(clip(pp[1] + v[1] + u[1], -64'sd2147483648, 64'sd2147483647));
      r.pz = sfk_pkg::PW'(clip(pp[2] + v[2] + u[2], -64'sd2147483648, 64'sd2147483647));
    end
    fk_rot[c][0] = r.qw; fk_rot[c][1] = r.qx; fk_rot[c][2] = r.qy; fk_rot[c][3] = r.qz;
    fk_pos[c][0] = r.px; fk_pos[c][1] = r.py; fk_pos[c][2] = r.pz;
    fk_count = (j.last || c + 1 >= NJ) ? 0 : c + 1;
    return r;
  endfunction

  function automatic logic [31:0] rnd_edge32();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rnd_q();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h4000;
      3: return 16'($urandom_range(0, 8191) - 4096);  // near zero
      default: return 16'($urandom);
    endcase
  endfunction

  // random joint; position index picks a legal parent most of the time
  function automatic joint_word_t rnd_joint(int pos, bit last);
    joint_word_t j;
    int k;
    j.qw = rnd_q(); j.qx = rnd_q(); j.qy = rnd_q(); j.qz = rnd_q();
    j.ox = rnd_edge32(); j.oy = rnd_edge32(); j.oz = rnd_edge32();
    j.rx = rnd_edge32(); j.ry = rnd_edge32(); j.rz = rnd_edge32();
    j.last = last;
    k = $urandom_range(0, 99);
    if (pos == 0 || k < 8) j.parent = sfk_pkg::ROOT_PARENT;
    else if (k < 88) j.parent = sfk_pkg::PARENT_W'($urandom_range(0, pos - 1));
    else if (k < 95)   // forward reference
      j.parent = sfk_pkg::PARENT_W'($urandom_range(pos, 63));
    else               // negative, not a root mark
      j.parent = sfk_pkg::PARENT_W'(-($urandom_range(2, 64)));
    return j;
  endfunction

  function automatic joint_word_t plain_joint(logic signed [sfk_pkg::PARENT_W-1:0] par,
                                              bit last);
    joint_word_t j;
    j = '0;
    j.parent = par; j.qw = sfk_pkg::Q_ONE; j.last = last;
    j.ox = 32'sh0001_0000;
    return j;
  endfunction

  // stimulus
  initial begin
    joint_word_t j;
    int n, len;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // directed: identity chain, extremes, bad parents, a one-joint pose
    j = plain_joint(sfk_pkg::ROOT_PARENT, 1'b0); j.rx = 32'h7fff_ffff; j.ry = 32'h8000_0000;
    queue_joint(j);
    j = plain_joint(7'sd0, 1'b0);
    j.qw = 16'h7fff; j.qx = 16'h7fff; j.qy = 16'h8000; j.qz = 16'h8000;
    j.ox = 32'h7fff_ffff; j.oy = 32'h8000_0000; j.oz = 32'h7fff_ffff;
    queue_joint(j);
    j = plain_joint(7'sd1, 1'b0);
    j.qw = 16'h8000; j.qx = 16'h8000; j.qy = 16'h7fff; j.qz = 16'h7fff;
    j.ox = 32'h8000_0000; j.oy = 32'h7fff_ffff; j.oz = 32'h8000_0000;
    queue_joint(j);
    queue_joint(plain_joint(7'sd3, 1'b0));     // self parent
    queue_joint(plain_joint(7'sd63, 1'b0));    // forward parent, top value
    queue_joint(plain_joint(-7'sd64, 1'b0));   // most negative
    queue_joint(plain_joint(-7'sd2, 1'b0));
    j = plain_joint(sfk_pkg::ROOT_PARENT, 1'b1); j.rz = 32'hffff_ffff; j.qz = 16'hffff;
    queue_joint(j);
    queue_joint(plain_joint(sfk_pkg::ROOT_PARENT, 1'b1));  // single-joint pose
    j = plain_joint(7'sd0, 1'b0);
    j.qw = 16'h7fff; j.qx = 16'h7fff; j.qy = 16'h7fff; j.qz = 16'h7fff;
    queue_joint(j);                                       // parent 0 at index 0 is bad
    queue_joint(rnd_joint(1, 1'b1));
    // full 64-joint pose with no tlast: counter wraps on its own
    for (int i = 0; i < NJ; i++) queue_joint(rnd_joint(i, 1'b0));
    // random poses
    n = 0;
    while (n < 1620) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) queue_joint(rnd_joint(i, i == len - 1));
      n += len;
    end
    wait (joint_queue.size() == 0 && !in_tvalid);
    stim_done = 1'b1;
  end

  // hold a long stretch without idling in the middle of the run
  always @(posedge clk) quiet <= (pose_queue.size() + joint_queue.size() > 0) &&
                                 joint_queue.size() inside {[600:900]};

  // driver: present the next joint, hold it until accepted
  always @(posedge clk) begin
    joint_word_t j;
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (joint_queue.size() > 0 && (quiet || $urandom_range(0, 99) >= 11)) begin
          j = joint_queue.pop_front();
          in_tdata <= {1'b0, j.rz, j.ry, j.rx, j.oz, j.oy, j.ox, j.qz, j.qy, j.qx, j.qw,
                       j.parent};
          in_tlast <= j.last;
          in_tvalid <= 1'b1;
          pose_queue.insert(pose_queue.size(), solve_joint(j));
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= quiet || $urandom_range(0, 99) >= 11;
    end
  end

  // monitor: compare each result word with the oldest expectation
  always @(posedge clk) begin
    pose_word_t e, a;
    if (rst_n && out_tvalid && out_tready) begin
      a = {out_tdata[5:0], out_tdata[21:6], out_tdata[37:22], out_tdata[53:38],
           out_tdata[69:54], out_tdata[101:70], out_tdata[133:102], out_tdata[165:134],
           out_tuser};
      if (pose_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", a);
      end else begin
        e = pose_queue.pop_front();
        if (a !== e) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("joint %0d: expected rot %0d %0d %0d %0d pos %0d %0d %0d bad %0b",
                     e.idx, e.qw, e.qx, e.qy, e.qz, e.px, e.py, e.pz, e.bad);
            $display("  got rot %0d %0d %0d %0d pos %0d %0d %0d bad %0b",
                     a.qw, a.qx, a.qy, a.qz, a.px, a.py, a.pz, a.bad);
          end
          if (mismatches <= 10 && a.idx != e.idx)
            $display("  joint index expected %0d got %0d", e.idx, a.idx);
        end
      end
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("skeleton_forward_kinematics_test: errors");
      $finish;
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    wait (pose_queue.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pose_queue.size() == 0) begin
      $display("skeleton_forward_kinematics_test: clean");
    end else begin
      $display("skeleton_forward_kinematics_test: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
